// ===== src/cpra_pkg.sv =====
// ----------------------------------------------------------------------------
// cpra_pkg
// Shared types, widths, constants and helper functions for the complex
// polar/rectangular arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpra_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int FRAC_BITS     = 16;
  localparam int GUARD         = 8;

  // 1/K in Q31.
  localparam logic [30:0] INV_GAIN = 31'h4DBA76D4;

  // Rotator, vectoring and angle accumulator widths.
  localparam int RW = 32 + GUARD + 2;
  localparam int VW = RW + 3;
  localparam int ZW = 34;

  // Quotient width of the polar divide.
  localparam int QW = 32 + FRAC_BITS;

  typedef enum logic [2:0] {
    ACT_P2R  = 3'd0,
    ACT_R2P  = 3'd1,
    ACT_ADD  = 3'd2,
    ACT_SUB  = 3'd3,
    ACT_PSUB = 3'd4,
    ACT_PMUL = 3'd5,
    ACT_RMUL = 3'd6,
    ACT_PDIV = 3'd7
  } action_t;

  // Result fields that travel beside the CORDIC datapath.
  typedef struct packed {
    action_t     act;
    logic [31:0] ra;
    logic [31:0] rb;
    logic        ov;
    logic        dz;
    logic        dgo;
    logic        dneg;
  } side_t;

  typedef struct packed {
    logic signed [RW-1:0] x1;
    logic signed [RW-1:0] y1;
    logic signed [ZW-1:0] z1;
    logic signed [RW-1:0] x2;
    logic signed [RW-1:0] y2;
    logic signed [ZW-1:0] z2;
    logic                 byp;
  } rot_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 off;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic [31:0]   rem;
    logic [QW-1:0] num;
    logic [31:0]   den;
  } div_t;

  function automatic logic [31:0] atan_tab(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Saturate to the signed 32-bit range; the top bit of the result is the flag.
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // One rotation-mode step on both rotators; a set byp leaves them unchanged.
  function automatic rot_t rot_iter(input rot_t q, input int unsigned i);
    rot_t        n;
    logic [ZW-1:0] at;
    n  = q;
    at = ZW'(atan_tab(i));
    if (!q.byp) begin
      if (!q.z1[ZW-1]) begin
        n.x1 = $signed(q.x1) - ($signed(q.y1) >>> i);
        n.y1 = $signed(q.y1) + ($signed(q.x1) >>> i);
        n.z1 = q.z1 - at;
      end else begin
        n.x1 = $signed(q.x1) + ($signed(q.y1) >>> i);
        n.y1 = $signed(q.y1) - ($signed(q.x1) >>> i);
        n.z1 = q.z1 + at;
      end
      if (!q.z2[ZW-1]) begin
        n.x2 = $signed(q.x2) - ($signed(q.y2) >>> i);
        n.y2 = $signed(q.y2) + ($signed(q.x2) >>> i);
        n.z2 = q.z2 - at;
      end else begin
        n.x2 = $signed(q.x2) + ($signed(q.y2) >>> i);
        n.y2 = $signed(q.y2) - ($signed(q.x2) >>> i);
        n.z2 = q.z2 + at;
      end
    end
    return n;
  endfunction

  // One vectoring-mode step.
  function automatic vec_t vec_iter(input vec_t q, input int unsigned i);
    vec_t          n;
    logic [ZW-1:0] at;
    n  = q;
    at = ZW'(atan_tab(i));
    if (!q.y[VW-1]) begin
      n.x = $signed(q.x) + ($signed(q.y) >>> i);
      n.y = $signed(q.y) - ($signed(q.x) >>> i);
      n.z = q.z + at;
    end else begin
      n.x = $signed(q.x) - ($signed(q.y) >>> i);
      n.y = $signed(q.y) + ($signed(q.x) >>> i);
      n.z = q.z - at;
    end
    return n;
  endfunction

  // One restoring division step: one quotient bit.
  function automatic div_t div_step(input div_t d);
    div_t        n;
    logic [32:0] r2;
    n  = d;
    r2 = {d.rem, d.num[QW-1]};
    if (r2 >= {1'b0, d.den}) begin
      n.rem = 32'(r2 - {1'b0, d.den});
      n.num = {d.num[QW-2:0], 1'b1};
    end else begin
      n.rem = r2[31:0];
      n.num = {d.num[QW-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== src/complex_polar_rect_arith_unit_top.sv =====
// Throughput: one word per cycle unless out_ready stalls the output; every stage
// registers its data with its own valid bit.
// The rate is set by the unrolled CORDIC rotate and vector stages, one step each.
// The divider retires its quotient bits across those same stages.
// Reset clears all valid bits; datapath registers are not reset.
// ----------------------------------------------------------------------------
// complex_polar_rect_arith_unit_top
// Pipelined complex arithmetic unit: polar/rectangular conversion, add,
// subtract, multiply and divide on Q16.16 values and binary angles.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_polar_rect_arith_unit_top import cpra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  input  logic signed [31:0] op_c,
  input  logic signed [31:0] op_d,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_a,
  output logic signed [31:0] res_b,
  output logic               overflow,
  output logic               div_by_zero
);

  localparam int ST_IN  = 0;
  localparam int ST_MUL = 1;
  localparam int ST_PRE = 2;
  localparam int ST_ROT = 3;
  localparam int ST_V0  = ST_ROT + CORDIC_STAGES;
  localparam int ST_V1  = ST_V0 + 1;
  localparam int ST_VEC = ST_V1 + 1;
  localparam int ST_GM  = ST_VEC + CORDIC_STAGES;
  localparam int ST_GS  = ST_GM + 1;
  localparam int ST_OUT = ST_GS + 1;
  localparam int NST    = ST_OUT + 1;

  localparam int NK      = 2 * CORDIC_STAGES;
  localparam int DIV_PER = (QW + NK - 1) / NK;
  localparam int HIW     = VW - 1 - 32;

  localparam logic signed [64:0] FRAC_HALF = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [RW:0] GRD_HALF  = (RW + 1)'(2 ** (GUARD - 1));

  // ---------------------------------------------------------------------
  // Valid bits and stall chain. A stage loads when it is empty or when
  // the stage after it loads, so bubbles are squeezed out.
  // ---------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  assign in_ready  = en[ST_IN];
  assign out_valid = vld[NST-1];

  // ---------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------
  action_t            act_i;
  logic signed [31:0] a_i, b_i, c_i, d_i;

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      act_i <= action_t'(action);
      a_i   <= op_a;
      b_i   <= op_b;
      c_i   <= op_c;
      d_i   <= op_d;
    end
  end

  // ---------------------------------------------------------------------
  // Multiply stage: gain products, complex products, simple results.
  // ---------------------------------------------------------------------
  logic signed [31:0] inv_s;
  logic signed [63:0] ga_m, gc_m, pac_m, pbd_m, pad_m, pbc_m;
  logic signed [31:0] a_m, b_m, d_m;
  side_t              side_q [ST_MUL:ST_GS];
  div_t               div_q  [ST_MUL:ST_GM-1];
  side_t              side_m;
  div_t               div_m;
  logic [32:0]        sat_ra, sat_rb;

  assign inv_s = $signed({1'b0, INV_GAIN});

  always_comb begin
    side_m      = '0;
    side_m.act  = act_i;
    sat_ra      = '0;
    sat_rb      = '0;
    case (act_i)
      ACT_ADD: begin
        sat_ra    = sat32(66'(a_i) + 66'(c_i));
        sat_rb    = sat32(66'(b_i) + 66'(d_i));
        side_m.ra = sat_ra[31:0];
        side_m.rb = sat_rb[31:0];
        side_m.ov = sat_ra[32] | sat_rb[32];
      end
      ACT_SUB: begin
        sat_ra    = sat32(66'(a_i) - 66'(c_i));
        sat_rb    = sat32(66'(b_i) - 66'(d_i));
        side_m.ra = sat_ra[31:0];
        side_m.rb = sat_rb[31:0];
        side_m.ov = sat_ra[32] | sat_rb[32];
      end
      ACT_PMUL: begin
        side_m.rb = b_i + d_i;
      end
      ACT_PDIV: begin
        side_m.rb = b_i - d_i;
        if (c_i == 32'sd0) begin
          side_m.dz = 1'b1;
          side_m.ra = a_i[31] ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
          side_m.dgo  = 1'b1;
          side_m.dneg = a_i[31] ^ c_i[31];
        end
      end
      default: begin
      end
    endcase

    div_m.rem = '0;
    div_m.num = {(a_i[31] ? 32'(-a_i) : 32'(a_i)), {FRAC_BITS{1'b0}}};
    div_m.den = c_i[31] ? 32'(-c_i) : 32'(c_i);
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      ga_m           <= a_i * inv_s;
      gc_m           <= c_i * inv_s;
      pac_m          <= a_i * c_i;
      pbd_m          <= b_i * d_i;
      pad_m          <= a_i * d_i;
      pbc_m          <= b_i * c_i;
      a_m            <= a_i;
      b_m            <= b_i;
      d_m            <= d_i;
      side_q[ST_MUL] <= side_m;
      div_q[ST_MUL]  <= div_m;
    end
  end

  // ---------------------------------------------------------------------
  // Pre stage: CORDIC start values with quadrant fold, product sums.
  // ---------------------------------------------------------------------
  logic signed [RW-1:0] gx1, gx2;
  logic signed [64:0]   sum1_p, sum2_p;
  rot_t                 rot_q [0:CORDIC_STAGES];
  rot_t                 rot_p;
  action_t              act_m;

  assign act_m = side_q[ST_MUL].act;
  assign gx1   = RW'(ga_m >>> (31 - GUARD));
  assign gx2   = RW'(gc_m >>> (31 - GUARD));

  always_comb begin
    rot_p     = '0;
    rot_p.byp = (act_m == ACT_R2P);
    if (act_m == ACT_R2P) begin
      rot_p.x1 = RW'(a_m) <<< GUARD;
      rot_p.y1 = RW'(b_m) <<< GUARD;
    end else begin
      // Second and third quadrant angles turn by pi with a negated start.
      if (b_m[31] ^ b_m[30]) begin
        rot_p.x1 = -gx1;
        rot_p.z1 = ZW'($signed({~b_m[31], b_m[30:0]}));
      end else begin
        rot_p.x1 = gx1;
        rot_p.z1 = ZW'(b_m);
      end
      if (act_m == ACT_PSUB) begin
        if (d_m[31] ^ d_m[30]) begin
          rot_p.x2 = -gx2;
          rot_p.z2 = ZW'($signed({~d_m[31], d_m[30:0]}));
        end else begin
          rot_p.x2 = gx2;
          rot_p.z2 = ZW'(d_m);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_PRE]) begin
      rot_q[0] <= rot_p;
      sum1_p   <= 65'(pac_m) - ((act_m == ACT_RMUL) ? 65'(pbd_m) : 65'sd0) + FRAC_HALF;
      sum2_p   <= 65'(pad_m) + 65'(pbc_m) + FRAC_HALF;
    end
  end

  // ---------------------------------------------------------------------
  // Rotation stages.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en[ST_ROT+i]) begin
        rot_q[i+1] <= rot_iter(rot_q[i], i);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Vector entry: difference, then fold into the right half plane.
  // ---------------------------------------------------------------------
  logic signed [VW-1:0] vx_0, vy_0;
  vec_t                 vec_q [0:CORDIC_STAGES];
  vec_t                 vec_p;

  always_ff @(posedge clk) begin
    if (en[ST_V0]) begin
      vx_0 <= VW'($signed(rot_q[CORDIC_STAGES].x1)) - VW'($signed(rot_q[CORDIC_STAGES].x2));
      vy_0 <= VW'($signed(rot_q[CORDIC_STAGES].y1)) - VW'($signed(rot_q[CORDIC_STAGES].y2));
    end
  end

  always_comb begin
    vec_p      = '0;
    vec_p.zero = (vx_0 == '0) && (vy_0 == '0);
    if (vx_0[VW-1]) begin
      vec_p.x   = -vx_0;
      vec_p.y   = -vy_0;
      vec_p.off = 1'b1;
    end else begin
      vec_p.x = vx_0;
      vec_p.y = vy_0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_V1]) begin
      vec_q[0] <= vec_p;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en[ST_VEC+i]) begin
        vec_q[i+1] <= vec_iter(vec_q[i], i);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Gain removal, split into a high and a low partial product.
  // ---------------------------------------------------------------------
  logic [VW-2:0]     ux;
  logic [HIW+30:0]   ph_g;
  logic [62:0]       pl_g;
  logic [31:0]       ang_g, ang_s;
  logic [VW-1:0]     mag_s;

  assign ux = vec_q[CORDIC_STAGES].x[VW-2:0];

  always_ff @(posedge clk) begin
    if (en[ST_GM]) begin
      ph_g  <= (HIW + 31)'(ux[VW-2:32]) * (HIW + 31)'(INV_GAIN);
      pl_g  <= 63'(ux[31:0]) * 63'(INV_GAIN);
      ang_g <= vec_q[CORDIC_STAGES].zero ? 32'd0 :
               {vec_q[CORDIC_STAGES].off, 31'd0} + vec_q[CORDIC_STAGES].z[31:0];
    end
    if (en[ST_GS]) begin
      mag_s <= VW'({ph_g, 1'b0}) + VW'(pl_g[62:31]);
      ang_s <= ang_g;
    end
  end

  // ---------------------------------------------------------------------
  // Divider steps, spread over the rotate and vector stages.
  // ---------------------------------------------------------------------
  for (genvar s = ST_PRE; s < ST_GM; s++) begin : g_div
    localparam bit IS_ROT = (s >= ST_ROT) && (s < ST_V0);
    localparam bit IS_VEC = (s >= ST_VEC) && (s < ST_GM);
    localparam int K      = IS_ROT ? (s - ST_ROT) :
                            (IS_VEC ? (CORDIC_STAGES + s - ST_VEC) : 0);
    div_t dn;
    always_comb begin
      dn = div_q[s-1];
      for (int j = 0; j < DIV_PER; j++) begin
        if ((IS_ROT || IS_VEC) && ((K * DIV_PER + j) < QW)) begin
          dn = div_step(dn);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[s]) begin
        div_q[s] <= dn;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Side results: finished at the stage where their data is ready.
  // ---------------------------------------------------------------------
  for (genvar s = ST_PRE; s <= ST_GS; s++) begin : g_side
    side_t sn;
    if (s == ST_ROT) begin : g_mul_fin
      logic [32:0] m1, m2;
      always_comb begin
        sn = side_q[s-1];
        m1 = sat32(66'(sum1_p >>> FRAC_BITS));
        m2 = sat32(66'(sum2_p >>> FRAC_BITS));
        if (sn.act == ACT_PMUL) begin
          sn.ra = m1[31:0];
          sn.ov = m1[32];
        end else if (sn.act == ACT_RMUL) begin
          sn.ra = m1[31:0];
          sn.rb = m2[31:0];
          sn.ov = m1[32] | m2[32];
        end
      end
    end else if (s == ST_V0) begin : g_p2r_fin
      logic signed [RW:0] rx, ry;
      logic [32:0]        t1, t2;
      always_comb begin
        sn = side_q[s-1];
        rx = (RW + 1)'($signed(rot_q[CORDIC_STAGES].x1)) + GRD_HALF;
        ry = (RW + 1)'($signed(rot_q[CORDIC_STAGES].y1)) + GRD_HALF;
        t1 = sat32(66'(rx >>> GUARD));
        t2 = sat32(66'(ry >>> GUARD));
        if (sn.act == ACT_P2R) begin
          sn.ra = t1[31:0];
          sn.rb = t2[31:0];
          sn.ov = t1[32] | t2[32];
        end
      end
    end else if (s == ST_GM) begin : g_div_fin
      logic [QW-1:0] q;
      always_comb begin
        sn = side_q[s-1];
        q  = div_q[ST_GM-1].num;
        if (sn.dgo) begin
          if (!sn.dneg) begin
            if (q > QW'(32'h7FFFFFFF)) begin
              sn.ra = 32'h7FFFFFFF;
              sn.ov = 1'b1;
            end else begin
              sn.ra = q[31:0];
            end
          end else begin
            if (q > QW'(32'h80000000)) begin
              sn.ra = 32'h80000000;
              sn.ov = 1'b1;
            end else begin
              sn.ra = 32'd0 - q[31:0];
            end
          end
        end
      end
    end else begin : g_pass
      assign sn = side_q[s-1];
    end
    always_ff @(posedge clk) begin
      if (en[s]) begin
        side_q[s] <= sn;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  logic [VW:0]       mag_r;
  logic [VW-GUARD:0] mag_q;
  action_t           out_act;
  side_t             side_o;

  assign side_o = side_q[ST_GS];
  assign mag_r  = (VW + 1)'(mag_s) + (VW + 1)'(2 ** (GUARD - 1));
  assign mag_q  = mag_r[VW:GUARD];

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_act <= side_o.act;
      if (side_o.act == ACT_R2P || side_o.act == ACT_PSUB) begin
        res_b       <= ang_s;
        div_by_zero <= 1'b0;
        if (mag_q > (VW - GUARD + 1)'(32'h7FFFFFFF)) begin
          res_a    <= 32'h7FFFFFFF;
          overflow <= 1'b1;
        end else begin
          res_a    <= mag_q[31:0];
          overflow <= 1'b0;
        end
      end else begin
        res_a       <= side_o.ra;
        res_b       <= side_o.rb;
        overflow    <= side_o.ov;
        div_by_zero <= side_o.dz;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(overflow && div_by_zero))
    else $error("overflow and div_by_zero raised together");

  a_dz_only_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_by_zero |-> out_act == ACT_PDIV)
    else $error("div_by_zero on an action other than polar divide");

  a_mag_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_act == ACT_R2P || out_act == ACT_PSUB) |-> !res_a[31])
    else $error("negative magnitude from vectoring");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

  a_first_stage_moves: assert property (@(posedge clk) disable iff (rst)
    vld[ST_IN] && !vld[ST_MUL] |=> vld[ST_MUL])
    else $error("word did not advance into an empty stage");

endmodule

`default_nettype wire

// ===== sim/cpra_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpra_checker
// Watches both channels of the complex arithmetic unit, computes the result
// each accepted word should give and compares it with each result word.
// ----------------------------------------------------------------------------
module cpra_checker import cpra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  input  logic signed [31:0] op_c,
  input  logic signed [31:0] op_d,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] res_a,
  input  logic signed [31:0] res_b,
  input  logic               overflow,
  input  logic               div_by_zero,
  output int                 errors,
  output int                 pending
);

  localparam logic [31:0] INV_K = 32'h4DBA76D4;

  typedef struct packed {
    logic [31:0] ra;
    logic [31:0] rb;
    logic        ov;
    logic        dz;
  } cplx_res_t;

  cplx_res_t want_q[$];

  function automatic logic [31:0] angle_step(input int unsigned i);
    logic [31:0] t [0:31];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
          32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
          32'h00000001, 32'h00000000};
    return t[i];
  endfunction

  function automatic longint rnd_shift(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip32(input longint v, inout logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Fixed-point products can reach 2^62 each, so sum them in pieces.
  function automatic longint prod_sum(input longint p1, input longint p2);
    longint q, r;
    q = (p1 >>> FRAC_BITS) + (p2 >>> FRAC_BITS);
    r = (p1 & 64'hFFFF) + (p2 & 64'hFFFF);
    return q + ((r + 64'h8000) >>> FRAC_BITS);
  endfunction

  function automatic void to_rect(input longint mag, input logic [31:0] ang,
                                  output longint xo, output longint yo);
    longint x, y, z, nx;
    x = (mag * longint'(INV_K)) >>> (31 - GUARD);
    y = 0;
    if (((ang + 32'h40000000) & 32'h80000000) != 0) begin
      x = -x;
      ang = ang + 32'h80000000;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - angle_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + angle_step(i);
      end
      x = nx;
    end
    xo = x;
    yo = y;
  endfunction

  function automatic void to_polar(input longint x, input longint y,
                                   output longint mag, output logic [31:0] ang);
    logic [31:0] off;
    longint z, nx;
    logic [63:0] ux;
    off = 0;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; off = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + angle_step(i);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - angle_step(i);
      end
      x = nx;
    end
    ang = off + z[31:0];
    ux = x;
    mag = (((ux >> 32) * INV_K) << 1) + (((ux & 64'hFFFFFFFF) * INV_K) >> 31);
  endfunction

  function automatic cplx_res_t compute_result(input action_t act, input longint a,
      input longint b, input longint c, input longint d);
    cplx_res_t r;
    longint ra, rb, x1, y1, x2, y2, m;
    logic [31:0] ang;
    logic ov;
    ov = 0;
    r.dz = 0;
    ra = 0;
    rb = 0;
    case (act)
      ACT_P2R: begin
        to_rect(a, b[31:0], x1, y1);
        ra = clip32(rnd_shift(x1, GUARD), ov);
        rb = clip32(rnd_shift(y1, GUARD), ov);
      end
      ACT_R2P: begin
        to_polar(a <<< GUARD, b <<< GUARD, m, ang);
        ra = clip32(rnd_shift(m, GUARD), ov);
        rb = ang;
      end
      ACT_ADD: begin
        ra = clip32(a + c, ov);
        rb = clip32(b + d, ov);
      end
      ACT_SUB: begin
        ra = clip32(a - c, ov);
        rb = clip32(b - d, ov);
      end
      ACT_PSUB: begin
        to_rect(a, b[31:0], x1, y1);
        to_rect(c, d[31:0], x2, y2);
        to_polar(x1 - x2, y1 - y2, m, ang);
        ra = clip32(rnd_shift(m, GUARD), ov);
        rb = ang;
      end
      ACT_PMUL: begin
        ra = clip32(prod_sum(a * c, 0), ov);
        rb = b + d;
      end
      ACT_RMUL: begin
        ra = clip32(prod_sum(a * c, -(b * d)), ov);
        rb = clip32(prod_sum(a * d, b * c), ov);
      end
      default: begin
        if (c == 0) begin
          r.dz = 1;
          ra = (a >= 0) ? 64'sd2147483647 : -64'sd2147483648;
        end else begin
          ra = clip32((a <<< FRAC_BITS) / c, ov);
        end
        rb = b - d;
      end
    endcase
    r.ra = ra[31:0];
    r.rb = rb[31:0];
    r.ov = ov;
    return r;
  endfunction

  always @(posedge clk) begin
    cplx_res_t w;
    if (rst) begin
      errors  <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        want_q.push_back(compute_result(action_t'(action), op_a, op_b, op_c, op_d));
      end
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result word: res_a %h res_b %h", res_a, res_b);
          errors <= errors + 1;
        end else begin
          w = want_q.pop_front();
          if (w.ra !== res_a || w.rb !== res_b || w.ov !== overflow
              || w.dz !== div_by_zero) begin
            errors <= errors + 1;
            if (w.ra !== res_a) $error("res_a: expected %h, got %h", w.ra, res_a);
            if (w.rb !== res_b) $error("res_b: expected %h, got %h", w.rb, res_b);
            if (w.ov !== overflow)
              $error("overflow: expected %b, got %b", w.ov, overflow);
            if (w.dz !== div_by_zero)
              $error("div_by_zero: expected %b, got %b", w.dz, div_by_zero);
          end
        end
      end
      pending <= want_q.size();
    end
  end

endmodule

// ===== sim/complex_polar_rect_arith_unit_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_polar_rect_arith_unit_top_test
// Drives directed corner words and random words of every action through the
// unit under varying input gaps and output stalls; the checker compares.
// ----------------------------------------------------------------------------
module complex_polar_rect_arith_unit_top_test;
  import cpra_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         action;
  logic signed [31:0] op_a, op_b, op_c, op_d;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] res_a, res_b;
  logic               overflow, div_by_zero;
  int                 errors, pending;
  int                 send_idle, recv_idle;

  complex_polar_rect_arith_unit_top DUT (.*);

  cpra_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 0;
      3: return $urandom_range(32'h1FFFFF) - 32'h100000;
      4: return $urandom_range(32'h7FFFF) - 32'h40000;
      default: return $urandom;
    endcase
  endfunction

  // Valid drops only while the sender idles, so back-to-back words keep it high.
  task automatic send_word(input action_t act, input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    action   <= act;
    op_a <= a; op_b <= b; op_c <= c; op_d <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input int count);
    for (int k = 0; k < count; k++) begin
      send_word(action_t'($urandom_range(7)), pick_operand(), pick_operand(),
                pick_operand(), pick_operand());
    end
  endtask

  initial begin
    int cnt;
    rst = 1; in_valid = 0; action = 0;
    op_a = 0; op_b = 0; op_c = 0; op_d = 0; out_ready = 0;
    send_idle = 29; recv_idle = 63;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Corner words: extreme operands, zero vector, zero divisor, negative magnitude.
    for (int k = 0; k < 8; k++) begin
      send_word(action_t'(k), 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    end
    send_word(ACT_R2P, 0, 0, 0, 0);
    send_word(ACT_R2P, 32'hFFFF0000, 32'h00010000, 0, 0);
    send_word(ACT_P2R, 32'hFFFF0000, 32'h20000000, 0, 0);
    send_word(ACT_PDIV, 32'h00010000, 32'h40000000, 0, 32'h10000000);
    send_word(ACT_PDIV, 32'h80000000, 32'h00000001, 0, 32'hFFFFFFFF);
    send_word(ACT_PDIV, 32'h80000000, 0, 32'hFFFFFFFF, 0);
    send_word(ACT_RMUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_word(ACT_PSUB, 32'h00010000, 32'h40000000, 32'h00010000, 32'h40000000);
    send_word(ACT_PMUL, 32'h80000000, 32'hFFFFFFFF, 32'h80000000, 32'h00000001);
    send_word(ACT_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF);
    send_random(200);
    in_valid <= 0;
    // Hold off until the pipeline has drained.
    cnt = 0;
    while (pending != 0 && cnt < 20000) begin
      @(posedge clk);
      cnt++;
    end
    send_idle = 63; recv_idle = 29;
    send_random(200);
    send_idle = 0; recv_idle = 0;
    send_random(200);
    in_valid <= 0;
    cnt = 0;
    while (pending != 0 && cnt < 100000) begin
      @(posedge clk);
      cnt++;
    end
    repeat (80) @(posedge clk);
    if (pending == 0 && errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
